// ===== rtl/core/imsu_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imsu_pkg
// Shared types and constants of the Ising Metropolis site update block.
// ----------------------------------------------------------------------------
package imsu_pkg;

  localparam int THR_W     = 17;
  localparam int CFG_W     = 51;
  localparam int CFG_IDX_W = 3;
  localparam int NUP_W     = 3;

  localparam logic [THR_W-1:0] THR_ALWAYS  = 17'h10000;
  localparam logic [CFG_W-1:0] WORD_ALWAYS = {3{THR_ALWAYS}};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROWS   = 3'd0,
    CFG_COLS   = 3'd1,
    CFG_WORD_A = 3'd2,
    CFG_WORD_B = 3'd3,
    CFG_WORD_C = 3'd4,
    CFG_WORD_D = 3'd5
  } cfg_idx_t;

  // Which site of the five-point stencil is addressed.
  typedef enum logic [2:0] {
    STEP_CENTER = 3'd0,
    STEP_RP     = 3'd1,
    STEP_RM     = 3'd2,
    STEP_CP     = 3'd3,
    STEP_CM     = 3'd4
  } step_t;

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_READ  = 5'b00100,
    S_LAST  = 5'b01000,
    S_WRITE = 5'b10000
  } state_t;

endpackage

// ===== rtl/core/imsu_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imsu_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module imsu_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== rtl/core/imsu_nbr_addr.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imsu_nbr_addr
// Address unit: forms the store address of the site or one of its four
// neighbours, wrapping rows and columns at the grid size in use.
// ----------------------------------------------------------------------------
module imsu_nbr_addr #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64
) (
  input  logic [$clog2(MAX_ROWS)-1:0]         row,
  input  logic [$clog2(MAX_COLS)-1:0]         col,
  input  imsu_pkg::step_t                     step,
  input  logic [$clog2(MAX_ROWS+1)-1:0]       n_rows,
  input  logic [$clog2(MAX_COLS+1)-1:0]       n_cols,
  output logic [$clog2(MAX_ROWS*MAX_COLS)-1:0] addr
);

  localparam int ROW_W  = $clog2(MAX_ROWS);
  localparam int COL_W  = $clog2(MAX_COLS);
  localparam int RCFG_W = $clog2(MAX_ROWS+1);
  localparam int CCFG_W = $clog2(MAX_COLS+1);
  localparam int ADDR_W = $clog2(MAX_ROWS*MAX_COLS);

  logic [RCFG_W-1:0] row_inc;
  logic [CCFG_W-1:0] col_inc;
  logic [ROW_W-1:0]  row_p, row_m, row_sel;
  logic [COL_W-1:0]  col_p, col_m, col_sel;

  always_comb begin
    row_inc = RCFG_W'(row) + RCFG_W'(1);
    col_inc = CCFG_W'(col) + CCFG_W'(1);
    row_p   = (row_inc >= n_rows) ? '0 : row_inc[ROW_W-1:0];
    col_p   = (col_inc >= n_cols) ? '0 : col_inc[COL_W-1:0];
    row_m   = (row == '0) ? ROW_W'(n_rows - RCFG_W'(1)) : row - ROW_W'(1);
    col_m   = (col == '0) ? COL_W'(n_cols - CCFG_W'(1)) : col - COL_W'(1);

    row_sel = row;
    col_sel = col;
    case (step)
      imsu_pkg::STEP_RP: row_sel = row_p;
      imsu_pkg::STEP_RM: row_sel = row_m;
      imsu_pkg::STEP_CP: col_sel = col_p;
      imsu_pkg::STEP_CM: col_sel = col_m;
      default: ;
    endcase

    addr = ADDR_W'(ADDR_W'(row_sel) * ADDR_W'(MAX_COLS)) + ADDR_W'(col_sel);
  end

endmodule

// ===== rtl/core/ising_metropolis_site_update.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ising_metropolis_site_update
// Takes one item at a time: the five spin reads go one by one through the
// single port of the spin store, and a site outside the grid skips them. No
// new item is taken until the result of the last one has been issued.
// After reset the block sweeps the store to all up, one site a cycle, and
// accepts no item until done.
// ----------------------------------------------------------------------------
module ising_metropolis_site_update #(
  parameter int MAX_ROWS    = 64,
  parameter int MAX_COLS    = 64,
  parameter int RANDOM_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // item channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_kind,
  input  logic [$clog2(MAX_ROWS)-1:0]         in_row,
  input  logic [$clog2(MAX_COLS)-1:0]         in_col,
  input  logic [RANDOM_BITS-1:0]              in_uniform_random,
  input  logic                                in_spin_value,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_flipped,
  output logic                                out_new_spin,
  output logic signed [4:0]                   out_bond_change,
  output logic signed [2:0]                   out_magnetization_change,
  // configuration
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [imsu_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [imsu_pkg::CFG_W-1:0]          cfg_wdata
);

  localparam int ROW_W  = $clog2(MAX_ROWS);
  localparam int COL_W  = $clog2(MAX_COLS);
  localparam int RCFG_W = $clog2(MAX_ROWS+1);
  localparam int CCFG_W = $clog2(MAX_COLS+1);
  localparam int DEPTH  = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int THR_W  = imsu_pkg::THR_W;
  localparam int CMP_W  = (RANDOM_BITS > THR_W) ? RANDOM_BITS : THR_W;
  localparam int NUP_W  = imsu_pkg::NUP_W;

  // Configuration registers.
  logic [RCFG_W-1:0]         rows_r;
  logic [CCFG_W-1:0]         cols_r;
  logic [imsu_pkg::CFG_W-1:0] word_a_r, word_b_r, word_c_r;
  logic [THR_W-1:0]          word_d_r;

  // Sequencer and item registers.
  imsu_pkg::state_t  state_r, state_nxt;
  imsu_pkg::step_t   step_r, step_d_r;
  logic              rd_pend_r;
  logic [ADDR_W-1:0] clr_addr_r;
  logic              kind_r, wval_r, oob_r, old_r;
  logic [ROW_W-1:0]  row_r;
  logic [COL_W-1:0]  col_r;
  logic [RANDOM_BITS-1:0] rnd_r;
  logic [NUP_W-1:0]  nup_r;

  // Result registers.
  logic              out_valid_r, flipped_r, new_spin_r;
  logic signed [4:0] bond_r;
  logic signed [2:0] mag_r;

  logic [RCFG_W-1:0] n_rows;
  logic [CCFG_W-1:0] n_cols;
  logic              in_accept, out_free, in_range;
  logic [ADDR_W-1:0] site_addr, ram_addr;
  imsu_pkg::step_t   addr_step;
  logic              ram_we, ram_wdata, ram_rdata;
  logic [THR_W-1:0]  thr;
  logic              accept_flip, nw;
  logic signed [5:0] sum6;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r   <= RCFG_W'(MAX_ROWS);
      cols_r   <= CCFG_W'(MAX_COLS);
      word_a_r <= imsu_pkg::WORD_ALWAYS;
      word_b_r <= imsu_pkg::WORD_ALWAYS;
      word_c_r <= imsu_pkg::WORD_ALWAYS;
      word_d_r <= imsu_pkg::THR_ALWAYS;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        imsu_pkg::CFG_ROWS:   rows_r   <= cfg_wdata[RCFG_W-1:0];
        imsu_pkg::CFG_COLS:   cols_r   <= cfg_wdata[CCFG_W-1:0];
        imsu_pkg::CFG_WORD_A: word_a_r <= cfg_wdata;
        imsu_pkg::CFG_WORD_B: word_b_r <= cfg_wdata;
        imsu_pkg::CFG_WORD_C: word_c_r <= cfg_wdata;
        imsu_pkg::CFG_WORD_D: word_d_r <= cfg_wdata[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // A size of zero acts as one; sizes beyond the maxima saturate.
  always_comb begin
    if (rows_r == '0)                      n_rows = RCFG_W'(1);
    else if (rows_r > RCFG_W'(MAX_ROWS))   n_rows = RCFG_W'(MAX_ROWS);
    else                                   n_rows = rows_r;
    if (cols_r == '0)                      n_cols = CCFG_W'(1);
    else if (cols_r > CCFG_W'(MAX_COLS))   n_cols = CCFG_W'(MAX_COLS);
    else                                   n_cols = cols_r;
  end

  assign in_stall  = (state_r != imsu_pkg::S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign in_range  = (RCFG_W'(in_row) < n_rows) && (CCFG_W'(in_col) < n_cols);

  assign addr_step = (state_r == imsu_pkg::S_READ) ? step_r : imsu_pkg::STEP_CENTER;

  imsu_nbr_addr #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_nbr_addr (
    .row    (row_r),
    .col    (col_r),
    .step   (addr_step),
    .n_rows (n_rows),
    .n_cols (n_cols),
    .addr   (site_addr)
  );

  // Threshold picked by old spin and number of up neighbours.
  always_comb begin
    case ({old_r, nup_r})
      4'b0000: thr = word_a_r[THR_W-1:0];
      4'b0001: thr = word_a_r[2*THR_W-1:THR_W];
      4'b0010: thr = word_a_r[3*THR_W-1:2*THR_W];
      4'b0011: thr = word_b_r[THR_W-1:0];
      4'b0100: thr = word_b_r[2*THR_W-1:THR_W];
      4'b1000: thr = word_b_r[3*THR_W-1:2*THR_W];
      4'b1001: thr = word_c_r[THR_W-1:0];
      4'b1010: thr = word_c_r[2*THR_W-1:THR_W];
      4'b1011: thr = word_c_r[3*THR_W-1:2*THR_W];
      4'b1100: thr = word_d_r;
      default: thr = '0;
    endcase
  end

  always_comb begin
    accept_flip = CMP_W'(rnd_r) < CMP_W'(thr);
    if (kind_r) nw = wval_r;
    else        nw = accept_flip ? !old_r : old_r;
    // Neighbour sum times two, i.e. the bond change for an up flip.
    sum6 = $signed({1'b0, nup_r, 2'b00}) - 6'sd8;
  end

  // Store port: clear sweep, stencil reads, then the write-back.
  always_comb begin
    ram_we    = 1'b0;
    ram_wdata = nw;
    ram_addr  = site_addr;
    if (state_r == imsu_pkg::S_CLEAR) begin
      ram_we    = 1'b1;
      ram_wdata = 1'b1;
      ram_addr  = clr_addr_r;
    end else if (state_r == imsu_pkg::S_WRITE && out_free && !oob_r) begin
      ram_we = 1'b1;
    end
  end

  imsu_ram #(
    .WIDTH (1),
    .DEPTH (DEPTH)
  ) u_spin_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      imsu_pkg::S_CLEAR: begin
        if (clr_addr_r == ADDR_W'(DEPTH - 1)) state_nxt = imsu_pkg::S_IDLE;
      end
      imsu_pkg::S_IDLE: begin
        if (in_accept) state_nxt = in_range ? imsu_pkg::S_READ : imsu_pkg::S_WRITE;
      end
      imsu_pkg::S_READ: begin
        if (step_r == imsu_pkg::STEP_CM) state_nxt = imsu_pkg::S_LAST;
      end
      imsu_pkg::S_LAST:  state_nxt = imsu_pkg::S_WRITE;
      imsu_pkg::S_WRITE: begin
        if (out_free) state_nxt = imsu_pkg::S_IDLE;
      end
      default: state_nxt = imsu_pkg::S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= imsu_pkg::S_CLEAR;
      clr_addr_r  <= '0;
      step_r      <= imsu_pkg::STEP_CENTER;
      step_d_r    <= imsu_pkg::STEP_CENTER;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      rd_pend_r <= (state_r == imsu_pkg::S_READ);
      step_d_r  <= step_r;
      if (state_r == imsu_pkg::S_CLEAR) begin
        clr_addr_r <= clr_addr_r + ADDR_W'(1);
      end
      if (in_accept) begin
        step_r <= imsu_pkg::STEP_CENTER;
      end else if (state_r == imsu_pkg::S_READ) begin
        step_r <= imsu_pkg::step_t'(step_r + 3'd1);
      end
      if (state_r == imsu_pkg::S_WRITE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Item and result payload.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      kind_r <= in_kind;
      row_r  <= in_row;
      col_r  <= in_col;
      rnd_r  <= in_uniform_random;
      wval_r <= in_spin_value;
      oob_r  <= !in_range;
      nup_r  <= '0;
      old_r  <= 1'b0;
    end else if (rd_pend_r) begin
      if (step_d_r == imsu_pkg::STEP_CENTER) old_r <= ram_rdata;
      else                                  nup_r <= nup_r + NUP_W'(ram_rdata);
    end
    if (state_r == imsu_pkg::S_WRITE && out_free) begin
      if (oob_r) begin
        flipped_r  <= 1'b0;
        new_spin_r <= 1'b0;
        bond_r     <= '0;
        mag_r      <= '0;
      end else begin
        flipped_r  <= (nw != old_r);
        new_spin_r <= nw;
        if (nw == old_r) begin
          bond_r <= '0;
          mag_r  <= '0;
        end else if (nw) begin
          bond_r <= sum6[4:0];
          mag_r  <= 3'sd2;
        end else begin
          bond_r <= 5'(-sum6);
          mag_r  <= -3'sd2;
        end
      end
    end
  end

  assign out_valid                = out_valid_r;
  assign out_flipped              = flipped_r;
  assign out_new_spin             = new_spin_r;
  assign out_bond_change          = bond_r;
  assign out_magnetization_change = mag_r;

endmodule
